@@ src/acd_pkg.sv @@
// Package for the audio click declipper: result types, queue sizing and constants.
// No dependencies; the judge, the result queue and the core import it.
`default_nettype none

package acd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int THRESH_W = 15;

    // Result queue depth; two free slots are needed before a request is taken.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QLVL_W      = 3;

    localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 15'd4096;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        sample_t sample;
        logic    last;
    } result_t;

    // Results produced by one accepted request, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

@@ src/acd_if.sv @@
// Handshake interfaces of the audio click declipper: samples in, results out, configuration.
// Stand-alone; no package needed.
`default_nettype none

interface acd_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic               block_end;

    modport source (output valid, output sample_in, output block_end, input ready);
    modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface acd_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic               block_last;

    modport source (output valid, output sample_out, output block_last, input ready);
    modport sink   (input valid, input sample_out, input block_last, output ready);
endinterface

interface acd_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] spike_threshold;

    modport source (output valid, output spike_threshold, input ready);
    modport sink   (input valid, input spike_threshold, output ready);
endinterface

`default_nettype wire

@@ src/acd_judge.sv @@
// Three-point click test: decides whether the middle sample is a click and repairs it.
// Depends on acd_pkg.
`default_nettype none

module acd_judge (
    input  wire acd_pkg::sample_t               prev,
    input  wire acd_pkg::sample_t               cur,
    input  wire acd_pkg::sample_t               nxt,
    input  wire logic [acd_pkg::THRESH_W-1:0]   threshold,
    output acd_pkg::sample_t                    result
);
    import acd_pkg::*;

    logic signed [SAMPLE_W:0] diff_cp;
    logic signed [SAMPLE_W:0] diff_cn;
    logic signed [SAMPLE_W:0] diff_np;
    logic        [SAMPLE_W:0] mag_cp;
    logic        [SAMPLE_W:0] mag_cn;
    logic        [SAMPLE_W:0] mag_np;
    logic        [SAMPLE_W:0] mag_min;
    logic        [SAMPLE_W:0] thresh_ext;
    logic        [SAMPLE_W+1:0] near_twice;
    logic signed [SAMPLE_W:0] pair_sum;
    logic signed [SAMPLE_W:0] pair_rnd;
    logic                     is_click;

    assign diff_cp = {cur[SAMPLE_W-1], cur} - {prev[SAMPLE_W-1], prev};
    assign diff_cn = {cur[SAMPLE_W-1], cur} - {nxt[SAMPLE_W-1], nxt};
    assign diff_np = {nxt[SAMPLE_W-1], nxt} - {prev[SAMPLE_W-1], prev};

    assign mag_cp = diff_cp[SAMPLE_W] ? (SAMPLE_W+1)'(0) - diff_cp : diff_cp;
    assign mag_cn = diff_cn[SAMPLE_W] ? (SAMPLE_W+1)'(0) - diff_cn : diff_cn;
    assign mag_np = diff_np[SAMPLE_W] ? (SAMPLE_W+1)'(0) - diff_np : diff_np;

    assign mag_min    = (mag_cp < mag_cn) ? mag_cp : mag_cn;
    assign thresh_ext = {{(SAMPLE_W+1-THRESH_W){1'b0}}, threshold};
    assign near_twice = {mag_np, 1'b0};

    assign is_click = (mag_cp > thresh_ext) && (mag_cn > thresh_ext)
                   && ({1'b0, mag_min} > near_twice);

    // Adding the sign bit before the shift makes the halving truncate toward zero.
    assign pair_sum = {prev[SAMPLE_W-1], prev} + {nxt[SAMPLE_W-1], nxt};
    assign pair_rnd = pair_sum + {{SAMPLE_W{1'b0}}, pair_sum[SAMPLE_W]};

    assign result = is_click ? sample_t'(pair_rnd[SAMPLE_W:1]) : cur;

endmodule

`default_nettype wire

@@ src/acd_result_queue.sv @@
// Result queue: takes up to two results per cycle; sends one per ready cycle.
// Depends on acd_pkg and the acd_result_if interface.
`default_nettype none

module acd_result_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire acd_pkg::push_t             push,
    output logic [acd_pkg::QLVL_W-1:0]      level,
    acd_result_if.source                    result_ch
);
    import acd_pkg::*;

    result_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QLVL_W-1:0]   level_reg;
    logic [QLVL_W-1:0]   level_next;
    logic [QPTR_W-1:0]   wr_ptr_plus1;
    logic                pop;

    assign pop          = result_ch.valid && result_ch.ready;
    assign wr_ptr_plus1 = wr_ptr_reg + QPTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        level_next  = level_reg + QLVL_W'(push.count) - QLVL_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assign level                = level_reg;
    assign result_ch.valid      = (level_reg != '0);
    assign result_ch.sample_out = mem_reg[rd_ptr_reg].sample;
    assign result_ch.block_last = mem_reg[rd_ptr_reg].last;

endmodule

`default_nettype wire

@@ src/audio_click_declipper_core.sv @@
// Top level of the audio click declipper: sample holding, click test and result queue.
// Depends on acd_pkg, acd_if, acd_judge and acd_result_queue.
`default_nettype none

// Takes one 16-bit sample per cycle while the queue has room and repairs isolated clicks
// with a three-point test. Each sample is held until its successor arrives; the last
// sample of a block is sent with its predecessor, so a request with block_end set can
// give two results. Results leave through a four-entry queue, one per cycle while the
// receiver is ready, and a request is taken whenever at least two queue slots are free,
// so a continuous stream runs at one sample per cycle while results drain. The judgment
// of a sample and the update of the previous output happen in the cycle its successor
// is accepted. The threshold port is always ready and should only be written while idle.
module audio_click_declipper_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    acd_sample_if.sink   sample_ch,
    acd_result_if.source result_ch,
    acd_cfg_if.sink      cfg_ch
);
    import acd_pkg::*;

    logic [THRESH_W-1:0] threshold_reg;
    sample_t             prev_reg;
    sample_t             prev_next;
    sample_t             held_reg;
    sample_t             held_next;
    logic                held_valid_reg;
    logic                held_valid_next;
    sample_t             judged;
    sample_t             in_sample;
    push_t               push;
    logic [QLVL_W-1:0]   level;
    logic                in_acc;

    assign in_sample       = sample_ch.sample_in;
    assign sample_ch.ready = (level <= QLVL_W'(QUEUE_DEPTH - 2));
    assign in_acc          = sample_ch.valid && sample_ch.ready;
    assign cfg_ch.ready    = 1'b1;

    acd_judge u_judge (
        .prev      (prev_reg),
        .cur       (held_reg),
        .nxt       (in_sample),
        .threshold (threshold_reg),
        .result    (judged)
    );

    always_comb
    begin
        prev_next       = prev_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        push.count      = 2'd0;
        push.first      = '{sample: judged, last: 1'b0};
        push.second     = '{sample: in_sample, last: 1'b1};
        if (in_acc)
        begin
            if (held_valid_reg)
            begin
                prev_next  = judged;
                push.count = 2'd1;
            end
            if (sample_ch.block_end)
            begin
                // The closing sample is its own successor, so it always passes.
                prev_next       = in_sample;
                held_valid_next = 1'b0;
                if (held_valid_reg)
                begin
                    push.count = 2'd2;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = '{sample: in_sample, last: 1'b1};
                end
            end
            else
            begin
                held_next       = in_sample;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            prev_reg       <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                threshold_reg <= cfg_ch.spike_threshold;
            end
            prev_reg       <= prev_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
        end
    end

    acd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .level     (level),
        .result_ch (result_ch)
    );

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= QLVL_W'(QUEUE_DEPTH))
        else $error("result queue level exceeds its depth");

    a_block_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && sample_ch.block_end) |=> !held_valid_reg)
        else $error("a sample is still held after a block end");

    a_pair_pushed: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && held_valid_reg && sample_ch.block_end)
        |=> (level == $past(level) + QLVL_W'(2)
                      - QLVL_W'($past(result_ch.valid && result_ch.ready))))
        else $error("block end with a held sample did not queue two results");

    a_plain_sample_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !sample_ch.block_end) |=> (held_valid_reg && held_reg == $past(in_sample)))
        else $error("ordinary sample was not held");
`endif

endmodule

`default_nettype wire
